/* rtl/core/fupd_pkg.sv */
// ----------------------------------------------------------------------------
// fupd_pkg
// Shared types, character codes and helpers for the form-urlencoded pair
// decoder.
// ----------------------------------------------------------------------------
package fupd_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_EQ     = 3'd1;
    localparam logic [2:0] ERR_EXTRA_EQ  = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd3;
    localparam logic [2:0] ERR_TRUNC_ESC = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       in_value;
        logic       pair_done;
        logic [2:0] error_code;
        logic       stream_done;
    } res_t;

    // one queue word: the results caused by one input byte
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } entry_t;

    // {ok, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

/* rtl/core/form_urlencoded_pair_decoder_core.sv */
// ----------------------------------------------------------------------------
// form_urlencoded_pair_decoder_core
// Streaming decoder for form-urlencoded key/value strings.
// ----------------------------------------------------------------------------
// Takes one raw byte per cycle on the s_ channel and gives decoded results on
// the m_ channel, one result per cycle while m_ready is high. A byte is decoded
// in the cycle it is accepted; its results reach m_valid through a four-word
// queue and the output register. Most bytes give one result or none, so the
// block keeps up with one byte per cycle; a byte that gives two results (a
// held ';' resolved as data, or a separator closed by string end) makes the
// output side deliver a second result, which the queue absorbs. s_ready drops
// only when the queue is full. cookie_mode is written through cfg_we/cfg_wdata;
// the user must write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module form_urlencoded_pair_decoder_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_raw_byte,
    input  logic       s_string_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_byte_valid,
    output logic       m_in_value,
    output logic       m_pair_done,
    output logic [2:0] m_error_code,
    output logic       m_stream_done
);
    import fupd_pkg::*;

    logic   push, pop, full, head_valid;
    entry_t push_data, head_data;

    assign s_ready = !full;

    fupd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_raw_byte   (s_raw_byte),
        .s_string_end (s_string_end),
        .push         (push),
        .push_data    (push_data)
    );

    fupd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    fupd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_data     (head_data),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_byte_valid  (m_byte_valid),
        .m_in_value    (m_in_value),
        .m_pair_done   (m_pair_done),
        .m_error_code  (m_error_code),
        .m_stream_done (m_stream_done)
    );

endmodule

/* rtl/core/fupd_front.sv */
// ----------------------------------------------------------------------------
// fupd_front
// Takes raw bytes, tracks escape/pair state and builds the results of each
// byte as one queue word.
// ----------------------------------------------------------------------------
module fupd_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    input  logic            s_valid,
    input  logic            s_ready,
    input  logic [7:0]      s_raw_byte,
    input  logic            s_string_end,
    output logic            push,
    output fupd_pkg::entry_t push_data
);
    import fupd_pkg::*;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_PCT  = 2'd1;
    localparam logic [1:0] ESC_HI   = 2'd2;

    logic       cookie_reg;
    logic       value_side_reg, value_side_next;
    logic [1:0] escape_stage_reg, escape_stage_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic       held_reg, held_next;
    logic       err_latched_reg, err_latched_next;

    res_t       res [2];
    logic [1:0] n;
    logic       accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        logic       v;
        logic       last_data;
        logic       handled;
        logic [2:0] err;
        logic [2:0] fin;
        logic [4:0] hx;
        logic [7:0] b;
        logic       end_w;
        b                 = s_raw_byte;
        end_w             = s_string_end;
        v                 = value_side_reg;
        last_data         = 1'b0;
        handled           = 1'b0;
        err               = ERR_NONE;
        fin               = ERR_NONE;
        hx                = hex_decode(b);
        n                 = 2'd0;
        res[0]            = '0;
        res[1]            = '0;
        escape_stage_next = escape_stage_reg;
        high_nibble_next  = high_nibble_reg;
        held_next         = held_reg;
        err_latched_next  = err_latched_reg;

        if (err_latched_reg) begin
            if (end_w) begin
                res[0].stream_done = 1'b1;
                n                  = 2'd1;
                v                  = 1'b0;
                err_latched_next   = 1'b0;
                escape_stage_next  = ESC_NONE;
                high_nibble_next   = 4'd0;
                held_next          = 1'b0;
            end
        end else begin
            if (held_reg) begin
                held_next = 1'b0;
                if (b == CH_SPACE) begin
                    if (escape_stage_reg != ESC_NONE) err = ERR_TRUNC_ESC;
                    else if (!v) err = ERR_NO_EQ;
                    else v = 1'b0;
                    if (err == ERR_NONE) begin
                        res[n[0]].pair_done = 1'b1;
                        n = n + 2'd1;
                    end
                    handled = 1'b1;
                end else begin
                    res[n[0]].data_byte  = CH_SEMI;
                    res[n[0]].byte_valid = 1'b1;
                    res[n[0]].in_value   = v;
                    n         = n + 2'd1;
                    last_data = 1'b1;
                end
            end

            if (!handled) begin
                if (escape_stage_reg != ESC_NONE) begin
                    if (hx[4]) begin
                        if (escape_stage_reg == ESC_PCT) begin
                            high_nibble_next  = hx[3:0];
                            escape_stage_next = ESC_HI;
                            last_data         = 1'b0;
                        end else begin
                            res[n[0]].data_byte  = {high_nibble_reg, hx[3:0]};
                            res[n[0]].byte_valid = 1'b1;
                            res[n[0]].in_value   = v;
                            n                 = n + 2'd1;
                            last_data         = 1'b1;
                            escape_stage_next = ESC_NONE;
                            high_nibble_next  = 4'd0;
                        end
                    end else if (b == CH_EQ || (!cookie_reg && b == CH_AMP)) begin
                        err = ERR_TRUNC_ESC;
                    end else begin
                        err = ERR_BAD_HEX;
                    end
                end else if (b == CH_PCT) begin
                    escape_stage_next = ESC_PCT;
                    last_data         = 1'b0;
                end else if (b == CH_EQ) begin
                    if (v) err = ERR_EXTRA_EQ;
                    else v = 1'b1;
                    last_data = 1'b0;
                end else if (!cookie_reg && b == CH_AMP) begin
                    if (!v) err = ERR_NO_EQ;
                    else v = 1'b0;
                    if (err == ERR_NONE) begin
                        res[n[0]].pair_done = 1'b1;
                        n = n + 2'd1;
                    end
                    last_data = 1'b0;
                end else if (cookie_reg && b == CH_SEMI && !end_w) begin
                    held_next = 1'b1;
                    last_data = 1'b0;
                end else begin
                    res[n[0]].data_byte  = (b == CH_PLUS) ? CH_SPACE : b;
                    res[n[0]].byte_valid = 1'b1;
                    res[n[0]].in_value   = v;
                    n         = n + 2'd1;
                    last_data = 1'b1;
                end
            end

            if (err != ERR_NONE) begin
                res[n[0]].error_code  = err;
                res[n[0]].stream_done = end_w;
                n = n + 2'd1;
                if (end_w) begin
                    v                 = 1'b0;
                    escape_stage_next = ESC_NONE;
                    high_nibble_next  = 4'd0;
                    held_next         = 1'b0;
                end else begin
                    err_latched_next = 1'b1;
                end
            end else if (end_w) begin
                // close the last pair, using the escape state after this byte
                if (escape_stage_next != ESC_NONE) fin = ERR_TRUNC_ESC;
                else if (!v) fin = ERR_NO_EQ;
                if (last_data) begin
                    res[n[0] ^ 1'b1].pair_done   = (fin == ERR_NONE);
                    res[n[0] ^ 1'b1].error_code  = fin;
                    res[n[0] ^ 1'b1].stream_done = 1'b1;
                end else begin
                    res[n[0]].pair_done   = (fin == ERR_NONE);
                    res[n[0]].error_code  = fin;
                    res[n[0]].stream_done = 1'b1;
                    n = n + 2'd1;
                end
                v                 = 1'b0;
                escape_stage_next = ESC_NONE;
                high_nibble_next  = 4'd0;
                held_next         = 1'b0;
            end
        end
        value_side_next = v;
    end

    assign push          = accept && (n != 2'd0);
    assign push_data.two = n[1];
    assign push_data.r0  = res[0];
    assign push_data.r1  = res[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cookie_reg       <= 1'b0;
            value_side_reg   <= 1'b0;
            escape_stage_reg <= ESC_NONE;
            high_nibble_reg  <= 4'd0;
            held_reg         <= 1'b0;
            err_latched_reg  <= 1'b0;
        end else begin
            if (cfg_we) cookie_reg <= cfg_wdata;
            if (accept) begin
                value_side_reg   <= value_side_next;
                escape_stage_reg <= escape_stage_next;
                high_nibble_reg  <= high_nibble_next;
                held_reg         <= held_next;
                err_latched_reg  <= err_latched_next;
            end
        end
    end

    // the last byte of a string always leaves the decoder clean
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_string_end) |=> (!value_side_reg && escape_stage_reg == ESC_NONE
                                      && !held_reg && !err_latched_reg))
        else $error("string end did not clear decoder state");

endmodule

/* rtl/core/fupd_queue.sv */
// ----------------------------------------------------------------------------
// fupd_queue
// Short queue of result words between the byte front end and the output side.
// ----------------------------------------------------------------------------
module fupd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  fupd_pkg::entry_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output fupd_pkg::entry_t head_data
);
    import fupd_pkg::*;

    entry_t         q_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg, count_next;

    assign full       = (count_reg == QAW'(0) + (QAW+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = q_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QAW+1)'(QDEPTH))
        else $error("queue count out of range");

endmodule

/* rtl/core/fupd_back.sv */
// ----------------------------------------------------------------------------
// fupd_back
// Drains queue words one result at a time into the output register.
// ----------------------------------------------------------------------------
module fupd_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  fupd_pkg::entry_t head_data,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_data_byte,
    output logic             m_byte_valid,
    output logic             m_in_value,
    output logic             m_pair_done,
    output logic [2:0]       m_error_code,
    output logic             m_stream_done
);
    import fupd_pkg::*;

    logic m_valid_reg;
    logic sub_reg;
    res_t out_reg;
    logic load;

    // output register free this cycle
    assign load = !m_valid_reg || m_ready;
    assign pop  = load && head_valid && (!head_data.two || sub_reg);

    always_ff @(posedge aclk) begin
        if (load && head_valid) out_reg <= sub_reg ? head_data.r1 : head_data.r0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sub_reg     <= 1'b0;
        end else if (load) begin
            m_valid_reg <= head_valid;
            if (head_valid) sub_reg <= head_data.two && !sub_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data_byte   = out_reg.data_byte;
    assign m_byte_valid  = out_reg.byte_valid;
    assign m_in_value    = out_reg.in_value;
    assign m_pair_done   = out_reg.pair_done;
    assign m_error_code  = out_reg.error_code;
    assign m_stream_done = out_reg.stream_done;

    // second half of a word is only ever pending while that word is at the head
    a_sub_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg |-> (head_valid && head_data.two))
        else $error("second result pending without a two-result word");

endmodule

/* bench/fupd_pair_checker.sv */
// ----------------------------------------------------------------------------
// fupd_pair_checker
// Watches both channels of the form-urlencoded pair decoder, decodes every
// accepted raw byte with its own copy of the parsing state and compares each
// delivered result word with the oldest expected one.
// ----------------------------------------------------------------------------
module fupd_pair_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_raw_byte,
    input  logic       s_string_end,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_data_byte,
    input  logic       m_byte_valid,
    input  logic       m_in_value,
    input  logic       m_pair_done,
    input  logic [2:0] m_error_code,
    input  logic       m_stream_done,
    output int         fail_count,
    output int         pending
);
    import fupd_pkg::*;

    logic       cookie_mode;
    logic       value_side;
    logic [1:0] esc_stage;
    logic [3:0] hi_nib;
    logic       semi_held;
    logic       dropping;

    res_t decoded_q[$];
    res_t want;
    res_t got;
    int   reported;

    function automatic res_t make_res(input logic [7:0] d, input logic bv, input logic iv,
                                      input logic pd, input logic [2:0] ec, input logic sd);
        res_t r;
        r.data_byte   = d;
        r.byte_valid  = bv;
        r.in_value    = iv;
        r.pair_done   = pd;
        r.error_code  = ec;
        r.stream_done = sd;
        return r;
    endfunction

    function void restart_string();
        value_side = 1'b0;
        esc_stage  = 2'd0;
        hi_nib     = 4'd0;
        semi_held  = 1'b0;
        dropping   = 1'b0;
    endfunction

    // closing a pair needs a finished escape and a value side
    function logic [2:0] end_of_pair();
        if (esc_stage != 2'd0) return ERR_TRUNC_ESC;
        if (!value_side) return ERR_NO_EQ;
        value_side = 1'b0;
        return ERR_NONE;
    endfunction

    task automatic decode_raw_byte(input logic [7:0] b, input logic last);
        res_t       outs [2];
        int         n;
        int         nib;
        logic       tail_is_data;
        logic       sep_taken;
        logic [2:0] err;
        logic [2:0] fin;
        n            = 0;
        nib          = -1;
        tail_is_data = 1'b0;
        sep_taken    = 1'b0;
        err          = ERR_NONE;

        if (dropping) begin
            if (last) begin
                decoded_q.insert(decoded_q.size(),
                                 make_res(8'd0, 1'b0, 1'b0, 1'b0, ERR_NONE, 1'b1));
                restart_string();
            end
            return;
        end

        // a held ';' is resolved by this byte whatever the mode is now
        if (semi_held) begin
            semi_held = 1'b0;
            if (b == CH_SPACE) begin
                err = end_of_pair();
                if (err == ERR_NONE) begin
                    outs[n] = make_res(8'd0, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b0);
                    n++;
                end
                sep_taken = 1'b1;
            end else begin
                outs[n] = make_res(CH_SEMI, 1'b1, value_side, 1'b0, ERR_NONE, 1'b0);
                n++;
                tail_is_data = 1'b1;
            end
        end

        if (!sep_taken) begin
            if (esc_stage != 2'd0) begin
                if (b >= 8'h30 && b <= 8'h39) nib = int'(b - 8'h30);
                else if (b >= 8'h41 && b <= 8'h46) nib = int'(b - 8'h41 + 8'd10);
                else if (b >= 8'h61 && b <= 8'h66) nib = int'(b - 8'h61 + 8'd10);
                if (nib >= 0) begin
                    if (esc_stage == 2'd1) begin
                        hi_nib       = nib[3:0];
                        esc_stage    = 2'd2;
                        tail_is_data = 1'b0;
                    end else begin
                        outs[n] = make_res({hi_nib, nib[3:0]}, 1'b1, value_side, 1'b0,
                                           ERR_NONE, 1'b0);
                        n++;
                        tail_is_data = 1'b1;
                        esc_stage    = 2'd0;
                        hi_nib       = 4'd0;
                    end
                end else if (b == CH_EQ || (!cookie_mode && b == CH_AMP)) begin
                    err = ERR_TRUNC_ESC;
                end else begin
                    err = ERR_BAD_HEX;
                end
            end else if (b == CH_PCT) begin
                esc_stage    = 2'd1;
                tail_is_data = 1'b0;
            end else if (b == CH_EQ) begin
                if (value_side) err = ERR_EXTRA_EQ;
                else value_side = 1'b1;
                tail_is_data = 1'b0;
            end else if (!cookie_mode && b == CH_AMP) begin
                err = end_of_pair();
                if (err == ERR_NONE) begin
                    outs[n] = make_res(8'd0, 1'b0, 1'b0, 1'b1, ERR_NONE, 1'b0);
                    n++;
                end
                tail_is_data = 1'b0;
            end else if (cookie_mode && b == CH_SEMI && !last) begin
                semi_held    = 1'b1;
                tail_is_data = 1'b0;
            end else begin
                outs[n] = make_res((b == CH_PLUS) ? CH_SPACE : b, 1'b1, value_side, 1'b0,
                                   ERR_NONE, 1'b0);
                n++;
                tail_is_data = 1'b1;
            end
        end

        if (err != ERR_NONE) begin
            outs[n] = make_res(8'd0, 1'b0, 1'b0, 1'b0, err, last);
            n++;
            if (last) restart_string();
            else dropping = 1'b1;
        end else if (last) begin
            fin = end_of_pair();
            // the closing mark rides on the last data word when there is one
            if (tail_is_data && n > 0) begin
                if (fin == ERR_NONE) outs[n-1].pair_done = 1'b1;
                else outs[n-1].error_code = fin;
                outs[n-1].stream_done = 1'b1;
            end else begin
                outs[n] = make_res(8'd0, 1'b0, 1'b0, fin == ERR_NONE, fin, 1'b1);
                n++;
            end
            restart_string();
        end

        for (int i = 0; i < n; i++) decoded_q.insert(decoded_q.size(), outs[i]);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cookie_mode = 1'b0;
            restart_string();
            decoded_q.delete();
        end else begin
            // the byte taken at this edge still sees the old mode
            if (s_valid && s_ready) decode_raw_byte(s_raw_byte, s_string_end);
            if (cfg_we) cookie_mode = cfg_wdata;
            if (m_valid && m_ready) begin
                got = make_res(m_data_byte, m_byte_valid, m_in_value, m_pair_done,
                               m_error_code, m_stream_done);
                if (decoded_q.size() == 0) begin
                    fail_count++;
                    if (reported < 10) begin
                        reported++;
                        $display({"unexpected word: byte=%02h bv=%0b iv=%0b pd=%0b",
                                  " err=%0d sd=%0b"},
                                 got.data_byte, got.byte_valid, got.in_value, got.pair_done,
                                 got.error_code, got.stream_done);
                    end
                end else begin
                    want = decoded_q.pop_front();
                    if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
                        got.in_value !== want.in_value || got.pair_done !== want.pair_done ||
                        got.error_code !== want.error_code ||
                        got.stream_done !== want.stream_done) begin
                        fail_count++;
                        if (reported < 10) begin
                            reported++;
                            $display({"mismatch: expected byte=%02h bv=%0b iv=%0b pd=%0b",
                                      " err=%0d sd=%0b"},
                                     want.data_byte, want.byte_valid, want.in_value,
                                     want.pair_done, want.error_code, want.stream_done);
                            $display({"          got      byte=%02h bv=%0b iv=%0b pd=%0b",
                                      " err=%0d sd=%0b"},
                                     got.data_byte, got.byte_valid, got.in_value,
                                     got.pair_done, got.error_code, got.stream_done);
                        end
                    end
                end
            end
        end
        pending = decoded_q.size();
    end

endmodule

/* bench/tb_form_urlencoded_pair_decoder_core.sv */
// ----------------------------------------------------------------------------
// tb_form_urlencoded_pair_decoder_core
// Drives encoded strings into the pair decoder in both separator modes: a
// directed set of corner strings, then mostly well-formed random pairs with
// some broken strings and noise, under changing idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_form_urlencoded_pair_decoder_core;
    import fupd_pkg::*;

    logic       aclk         = 1'b0;
    logic       aresetn      = 1'b0;
    logic       cfg_we       = 1'b0;
    logic       cfg_wdata    = 1'b0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [7:0] s_raw_byte   = 8'd0;
    logic       s_string_end = 1'b0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic [7:0] m_data_byte;
    logic       m_byte_valid;
    logic       m_in_value;
    logic       m_pair_done;
    logic [2:0] m_error_code;
    logic       m_stream_done;

    int fail_count;
    int pending;

    int tx_idle_pct     = 22;
    int rx_idle_pct     = 78;
    bit long_stall_req  = 1'b0;
    bit long_stall_done = 1'b0;
    int items_sent      = 0;

    logic [7:0] line_buf[$];

    always #1 aclk = ~aclk;

    form_urlencoded_pair_decoder_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_raw_byte    (s_raw_byte),
        .s_string_end  (s_string_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_byte_valid  (m_byte_valid),
        .m_in_value    (m_in_value),
        .m_pair_done   (m_pair_done),
        .m_error_code  (m_error_code),
        .m_stream_done (m_stream_done)
    );

    fupd_pair_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_raw_byte    (s_raw_byte),
        .s_string_end  (s_string_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_byte_valid  (m_byte_valid),
        .m_in_value    (m_in_value),
        .m_pair_done   (m_pair_done),
        .m_error_code  (m_error_code),
        .m_stream_done (m_stream_done),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (long_stall_req && !long_stall_done) begin
                long_stall_done = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        #800000;
        $display("[form_urlencoded_pair_decoder_core] ERROR");
        $finish;
    end

    task put_byte(input logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endtask

    task put_text(input string t);
        for (int i = 0; i < t.len(); i++) line_buf.insert(line_buf.size(), t[i]);
    endtask

    task send_line(input bit close);
        for (int i = 0; i < line_buf.size(); i++) begin
            while ($urandom_range(99) < tx_idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid      <= 1'b1;
            s_raw_byte   <= line_buf[i];
            s_string_end <= close && (i == line_buf.size() - 1);
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            items_sent++;
        end
        line_buf.delete();
    endtask

    // hold the sender until every expected word is out, then let the pipe empty
    task settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task set_cookie(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + v;
        return ($urandom_range(1) ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    function automatic logic [7:0] odd_byte();
        case ($urandom_range(9))
            0: return CH_PCT;
            1: return CH_EQ;
            2: return CH_AMP;
            3: return CH_SEMI;
            4: return CH_SPACE;
            5: return CH_PLUS;
            6: return 8'h41;
            7: return 8'h39;
            8: return 8'h67;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task put_token(input bit cookie);
        int         r;
        logic [7:0] v;
        r = $urandom_range(99);
        v = 8'($urandom_range(255));
        if (r < 55) begin
            case ($urandom_range(2))
                0: put_byte(8'(8'h30 + $urandom_range(9)));
                1: put_byte(8'(8'h61 + $urandom_range(25)));
                default: put_byte(8'(8'h41 + $urandom_range(25)));
            endcase
        end else if (r < 65) begin
            put_byte(CH_PLUS);
        end else if (r < 85) begin
            put_byte(CH_PCT);
            put_byte(hex_char(v[7:4]));
            put_byte(hex_char(v[3:0]));
        end else if (r < 92) begin
            // a ';' (or a space in ampersand mode) that does not start a separator
            put_byte(cookie ? CH_SEMI : (v[0] ? CH_SEMI : CH_SPACE));
            if (cookie) put_byte(8'(8'h61 + $urandom_range(25)));
        end else begin
            put_byte(8'($urandom_range(128, 255)));
        end
    endtask

    task build_pairs(input bit cookie);
        int npairs;
        npairs = $urandom_range(1, 4);
        for (int p = 0; p < npairs; p++) begin
            if (p > 0) begin
                if (cookie) begin
                    put_byte(CH_SEMI);
                    put_byte(CH_SPACE);
                end else begin
                    put_byte(CH_AMP);
                end
            end
            repeat ($urandom_range(4)) put_token(cookie);
            put_byte(CH_EQ);
            repeat ($urandom_range(5)) put_token(cookie);
        end
    endtask

    initial begin
        int pick;
        int block_start;
        int mode;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ampersand mode corner strings
        set_cookie(1'b0);
        put_byte(CH_EQ); put_text("%3d"); put_byte(CH_AMP);
        put_byte(8'h00); put_byte(CH_EQ); put_byte(CH_PLUS); put_byte(8'hFF);
        send_line(1'b1);
        put_text("a&b");  send_line(1'b1);
        put_text("a==");  send_line(1'b1);
        put_text("%&");   send_line(1'b1);
        put_text("%4g");  send_line(1'b1);
        put_text("=%4");  send_line(1'b1);
        put_text("k");    send_line(1'b1);

        // cookie mode: held ';' as separator, as data, and at string end
        settle();
        set_cookie(1'b1);
        put_text("a=;b; =;"); send_line(1'b1);
        // ';' held across a mode change
        put_text("=;"); send_line(1'b0);
        settle();
        set_cookie(1'b0);
        put_text(" "); send_line(1'b1);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 22;
                    rx_idle_pct = 78;
                end
                1: begin
                    tx_idle_pct = 78;
                    rx_idle_pct = 22;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (mode = 0; mode < 2; mode++) begin
                settle();
                set_cookie(mode[0]);
                if (ph == 2 && mode == 0) long_stall_req = 1'b1;
                block_start = items_sent;
                while (items_sent - block_start < 290) begin
                    pick = $urandom_range(99);
                    build_pairs(mode[0]);
                    if (pick >= 85) begin
                        line_buf.delete();
                        repeat ($urandom_range(1, 8)) put_byte(odd_byte());
                    end else if (pick >= 75) begin
                        line_buf[$urandom_range(line_buf.size() - 1)] = odd_byte();
                    end
                    send_line(1'b1);
                end
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("[form_urlencoded_pair_decoder_core] OK");
        end else begin
            $display("[form_urlencoded_pair_decoder_core] ERROR");
        end
        $finish;
    end

endmodule

/* form_urlencoded_pair_decoder_core.f */
rtl/core/fupd_pkg.sv
rtl/core/fupd_front.sv
rtl/core/fupd_queue.sv
rtl/core/fupd_back.sv
rtl/core/form_urlencoded_pair_decoder_core.sv
bench/fupd_pair_checker.sv
bench/tb_form_urlencoded_pair_decoder_core.sv
